### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### src/slbs_pkg.sv
`default_nettype none

package slbs_pkg;

   // width of the running byte counter
   localparam int POSITION_BITS = 32;
   localparam int FIELD_POS_BITS = 32;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // lexer modes
   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_STRING = 3'd1;
   localparam logic [2:0] MODE_LINE   = 3'd2;
   localparam logic [2:0] MODE_BLOCK  = 3'd3;
   localparam logic [2:0] MODE_STAR   = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_OPEN_STRING  = 2'd1;
   localparam logic [1:0] ERR_OPEN_COMMENT = 2'd2;

   // characters
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NL    = 8'h0a;

   typedef struct packed {
      logic [7:0]                out_byte;
      logic                      byte_valid;
      logic                      token_start;
      logic                      is_string;
      logic [FIELD_POS_BITS-1:0] byte_position;
      logic                      done_res;
      logic [1:0]                error_code;
   } rsp_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0a) || (b == 8'h0d);
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      case (b)
         8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h5e, 8'h28, 8'h29, 8'h7b,
         8'h7d, 8'h5b, 8'h5d, 8'h3b, 8'h2c, 8'h2e, 8'h3d: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // one result, kept character or empty, not final
   function automatic rsp_type make_rsp(input logic [7:0] b, input logic valid,
                                        input logic start, input logic str,
                                        input logic [POSITION_BITS-1:0] pos);
      rsp_type r;
      r.out_byte      = b;
      r.byte_valid    = valid;
      r.token_start   = start;
      r.is_string     = str;
      r.byte_position = FIELD_POS_BITS'(pos);
      r.done_res      = 1'b0;
      r.error_code    = ERR_NONE;
      return r;
   endfunction

endpackage

`default_nettype wire

### src/slbs_if.sv
`default_nettype none

// source byte channel
interface slbs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// token character channel
interface slbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        token_start;
   logic        is_string;
   logic [31:0] byte_position;
   logic        done_res;
   logic [1:0]  error_code;

   modport source (output valid, output out_byte, output byte_valid, output token_start,
                   output is_string, output byte_position, output done_res,
                   output error_code, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input token_start,
                   input is_string, input byte_position, input done_res,
                   input error_code, output ready);
endinterface

`default_nettype wire

### src/source_lexer_byte_stream.sv
`default_nettype none

// Streaming lexer front end: takes one source byte per cycle while req ready
// is high and drops whitespace and comments, emitting kept characters tagged
// with token start, string membership and byte offset. Each byte is
// processed in the cycle it is accepted and its results (none, one, or two
// when a held slash is released) go into a four-entry result queue that
// drains one transaction per cycle while rsp ready is high. req ready is high
// while the queue holds two or fewer results, so input runs at one byte per
// cycle whenever the result side keeps up. The last byte's final result
// carries done and the error code, and the lexer returns to its reset state.
module source_lexer_byte_stream (
   input  wire       clock,
   input  wire       reset,
   slbs_req_if.sink  req_if,
   slbs_rsp_if.source rsp_if
);
   import slbs_pkg::*;

   // lexer state
   logic [2:0]               mode_ff, mode_in;
   logic                     held_ff, held_in;
   logic [POSITION_BITS-1:0] hpos_ff, hpos_in;
   logic                     sep_ff, sep_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;

   // result queue
   rsp_type                   queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;

   // per-byte results
   rsp_type    res_a, res_b;
   logic [1:0] res_n;

   logic req_acc, rsp_acc;

   assign req_if.ready = (cnt_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign req_acc      = req_if.valid && req_if.ready;
   assign rsp_acc      = rsp_if.valid && rsp_if.ready;

   // byte classification and next state
   always_comb begin
      logic [7:0] b;
      logic       last;
      logic       handle;
      logic [2:0] mode_cur;
      logic [1:0] err;
      rsp_type    r;

      b        = req_if.in_byte;
      last     = req_if.in_last;
      handle   = 1'b1;
      mode_cur = (mode_ff > MODE_STAR) ? MODE_NORMAL : mode_ff;
      err      = ERR_NONE;
      r        = make_rsp(8'd0, 1'b0, 1'b0, 1'b0, pos_ff);

      mode_in = mode_cur;
      held_in = held_ff;
      hpos_in = hpos_ff;
      sep_in  = sep_ff;
      pos_in  = pos_ff + POSITION_BITS'(1);
      res_a   = r;
      res_b   = r;
      res_n   = 2'd0;

      // release or absorb a held slash
      if (held_ff) begin
         held_in = 1'b0;
         sep_in  = 1'b1;
         if (b == CH_SLASH) begin
            mode_in = MODE_LINE;
            handle  = 1'b0;
         end else if (b == CH_STAR) begin
            mode_in = MODE_BLOCK;
            handle  = 1'b0;
         end else begin
            res_a = make_rsp(CH_SLASH, 1'b1, 1'b1, 1'b0, hpos_ff);
            res_n = 2'd1;
         end
      end

      // mode handling of the current byte
      if (handle) begin
         r = make_rsp(8'd0, 1'b0, 1'b0, 1'b0, pos_ff);
         case (mode_cur)
            MODE_STRING: begin
               r = make_rsp(b, 1'b1, 1'b0, 1'b1, pos_ff);
               if (b == CH_QUOTE) begin
                  mode_in = MODE_NORMAL;
                  sep_in  = 1'b1;
               end
            end
            MODE_LINE: begin
               if (b == CH_NL) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (b == CH_STAR) mode_in = MODE_STAR;
            end
            MODE_STAR: begin
               if (b == CH_SLASH) mode_in = MODE_NORMAL;
               else if (b != CH_STAR) mode_in = MODE_BLOCK;
            end
            default: begin
               if (is_space(b)) begin
                  sep_in = 1'b1;
               end else if (b == CH_QUOTE) begin
                  r       = make_rsp(b, 1'b1, 1'b1, 1'b1, pos_ff);
                  mode_in = MODE_STRING;
               end else if (b == CH_SLASH && !last) begin
                  held_in = 1'b1;
                  hpos_in = pos_ff;
               end else if (is_punct(b)) begin
                  r      = make_rsp(b, 1'b1, 1'b1, 1'b0, pos_ff);
                  sep_in = 1'b1;
               end else begin
                  r      = make_rsp(b, 1'b1, sep_in, 1'b0, pos_ff);
                  sep_in = 1'b0;
               end
            end
         endcase
         if (r.byte_valid) begin
            if (res_n == 2'd0) res_a = r;
            else res_b = r;
            res_n = res_n + 2'd1;
         end
      end

      // end of text: mark final result and return to reset state
      if (last) begin
         if (mode_in == MODE_STRING) err = ERR_OPEN_STRING;
         else if (mode_in == MODE_BLOCK || mode_in == MODE_STAR) err = ERR_OPEN_COMMENT;
         if (res_n == 2'd0) begin
            res_a = make_rsp(8'd0, 1'b0, 1'b0, 1'b0, pos_ff);
            res_n = 2'd1;
         end
         if (res_n == 2'd1) begin
            res_a.done_res   = 1'b1;
            res_a.error_code = err;
         end else begin
            res_b.done_res   = 1'b1;
            res_b.error_code = err;
         end
         mode_in = MODE_NORMAL;
         held_in = 1'b0;
         hpos_in = '0;
         sep_in  = 1'b1;
         pos_in  = '0;
      end
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         held_ff <= 1'b0;
         hpos_ff <= '0;
         sep_ff  <= 1'b1;
         pos_ff  <= '0;
      end else if (req_acc) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         hpos_ff <= hpos_in;
         sep_ff  <= sep_in;
         pos_ff  <= pos_in;
      end
   end

   // queue occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (req_acc) cnt_in = cnt_in + QUEUE_CNT_BITS'(res_n);
      if (rsp_acc) cnt_in = cnt_in - QUEUE_CNT_BITS'(1);
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (req_acc) wr_ff <= wr_ff + QUEUE_PTR_BITS'(res_n);
         if (rsp_acc) rd_ff <= rd_ff + QUEUE_PTR_BITS'(1);
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (res_n != 2'd0) queue_ff[wr_ff] <= res_a;
         if (res_n == 2'd2) queue_ff[wr_ff + QUEUE_PTR_BITS'(1)] <= res_b;
      end
   end

   // result channel
   assign rsp_if.valid         = (cnt_ff != '0);
   assign rsp_if.out_byte      = queue_ff[rd_ff].out_byte;
   assign rsp_if.byte_valid    = queue_ff[rd_ff].byte_valid;
   assign rsp_if.token_start   = queue_ff[rd_ff].token_start;
   assign rsp_if.is_string     = queue_ff[rd_ff].is_string;
   assign rsp_if.byte_position = queue_ff[rd_ff].byte_position;
   assign rsp_if.done_res      = queue_ff[rd_ff].done_res;
   assign rsp_if.error_code    = queue_ff[rd_ff].error_code;

`include "assert_macros.svh"

   // queue never overfills
   `ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1, cnt_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
   // a held slash only exists in normal mode
   `ASSERT_IMPLIES(a_held_normal, clock, reset, held_ff, mode_ff == MODE_NORMAL)
   // last byte returns the lexer to its reset state
   `ASSERT_NEXT(a_last_resets, clock, reset, req_acc && req_if.in_last,
                mode_ff == MODE_NORMAL && !held_ff && sep_ff && pos_ff == '0)
   // every accepted byte ending a text leaves a result behind
   `ASSERT_NEXT(a_last_has_rsp, clock, reset, req_acc && req_if.in_last, cnt_ff != '0)

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
   import slbs_pkg::*;

   logic clock = 1'b0;
   logic reset;

   slbs_req_if req_if ();
   slbs_rsp_if rsp_if ();

   source_lexer_byte_stream DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // 10 unit clock period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lexer state as predicted from the accepted bytes
   logic [2:0]  lex_mode;
   logic        slash_waiting;
   logic [31:0] slash_at;
   logic        sep_seen;
   logic [31:0] next_pos;

   // token characters still to come, oldest first
   rsp_type expected_chars[$];

   int  mismatches = 0;
   int  bytes_sent = 0;
   int  stall_order = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;

   function automatic void lexer_clear();
      lex_mode      = MODE_NORMAL;
      slash_waiting = 1'b0;
      slash_at      = '0;
      sep_seen      = 1'b1;
      next_pos      = '0;
   endfunction

   function automatic logic blank_char(input logic [7:0] b);
      return b == " " || b == "\t" || b == "\n" || b == "\r";
   endfunction

   function automatic logic punct_char(input logic [7:0] b);
      case (b)
         "+", "-", "*", "/", "^", "(", ")", "{", "}", "[", "]", ";", ",", ".", "=": begin
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void expect_char(input logic [7:0] b, input logic valid,
                                       input logic start, input logic str,
                                       input logic [31:0] pos);
      rsp_type r;
      r.out_byte      = b;
      r.byte_valid    = valid;
      r.token_start   = start;
      r.is_string     = str;
      r.byte_position = pos;
      r.done_res      = 1'b0;
      r.error_code    = ERR_NONE;
      expected_chars.insert(expected_chars.size(), r);
   endfunction

   // work out the token characters that one accepted byte produces
   function automatic void lex_byte(input logic [7:0] b, input logic last);
      logic [31:0] here;
      logic        handle;
      int          before_cnt;
      logic [1:0]  err;
      rsp_type     tail;
      here = next_pos;
      handle = 1'b1;
      before_cnt = expected_chars.size();
      if (lex_mode > MODE_STAR) lex_mode = MODE_NORMAL;

      // a held slash is resolved by the byte after it
      if (slash_waiting) begin
         slash_waiting = 1'b0;
         if (b == CH_SLASH) begin
            lex_mode = MODE_LINE;
            sep_seen = 1'b1;
            handle = 1'b0;
         end else if (b == CH_STAR) begin
            lex_mode = MODE_BLOCK;
            sep_seen = 1'b1;
            handle = 1'b0;
         end else begin
            expect_char(CH_SLASH, 1'b1, 1'b1, 1'b0, slash_at);
            sep_seen = 1'b1;
         end
      end

      if (handle) begin
         case (lex_mode)
            MODE_STRING: begin
               expect_char(b, 1'b1, 1'b0, 1'b1, here);
               if (b == CH_QUOTE) begin
                  lex_mode = MODE_NORMAL;
                  sep_seen = 1'b1;
               end
            end
            MODE_LINE: begin
               if (b == CH_NL) lex_mode = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (b == CH_STAR) lex_mode = MODE_STAR;
            end
            MODE_STAR: begin
               if (b == CH_SLASH) lex_mode = MODE_NORMAL;
               else if (b != CH_STAR) lex_mode = MODE_BLOCK;
            end
            default: begin
               if (blank_char(b)) begin
                  sep_seen = 1'b1;
               end else if (b == CH_QUOTE) begin
                  expect_char(b, 1'b1, 1'b1, 1'b1, here);
                  lex_mode = MODE_STRING;
               end else if (b == CH_SLASH && !last) begin
                  slash_waiting = 1'b1;
                  slash_at = here;
               end else if (punct_char(b)) begin
                  expect_char(b, 1'b1, 1'b1, 1'b0, here);
                  sep_seen = 1'b1;
               end else begin
                  expect_char(b, 1'b1, sep_seen, 1'b0, here);
                  sep_seen = 1'b0;
               end
            end
         endcase
      end

      next_pos = next_pos + 32'd1;

      // final byte: done and error ride on the last result of the text
      if (last) begin
         err = ERR_NONE;
         if (lex_mode == MODE_STRING) err = ERR_OPEN_STRING;
         else if (lex_mode == MODE_BLOCK || lex_mode == MODE_STAR) err = ERR_OPEN_COMMENT;
         if (expected_chars.size() == before_cnt) expect_char(8'h00, 1'b0, 1'b0, 1'b0, here);
         tail = expected_chars[expected_chars.size() - 1];
         tail.done_res = 1'b1;
         tail.error_code = err;
         expected_chars[expected_chars.size() - 1] = tail;
         lexer_clear();
      end
   endfunction

   // idle length: mostly short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(20, 50);
   endfunction

   // offer one byte and wait until it is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (sender_idles && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      lex_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   // sender pauses until every expected character has arrived
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_chars.size() != 0);
   endtask

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 35);
      return (r < 26) ? 8'("a" + r) : 8'("0" + r - 26);
   endfunction

   function automatic logic [7:0] punct_pick();
      case ($urandom_range(0, 14))
         0: return "+";
         1: return "-";
         2: return "*";
         3: return "/";
         4: return "^";
         5: return "(";
         6: return ")";
         7: return "{";
         8: return "}";
         9: return "[";
         10: return "]";
         11: return ";";
         12: return ",";
         13: return ".";
         default: return "=";
      endcase
   endfunction

   function automatic logic [7:0] blank_pick();
      case ($urandom_range(0, 3))
         0: return " ";
         1: return "\t";
         2: return "\n";
         default: return "\r";
      endcase
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 255));
         1: return CH_STAR;
         2: return CH_SLASH;
         3: return CH_QUOTE;
         4: return blank_pick();
         5: return punct_pick();
         default: return word_char();
      endcase
   endfunction

   // mostly well-formed lexemes with random content, cut at the goal length
   function automatic void build_text(ref logic [7:0] text[$], input int goal);
      logic [7:0] c;
      text.delete();
      while (text.size() < goal) begin
         case ($urandom_range(0, 11))
            0, 1: repeat ($urandom_range(1, 6)) text.insert(text.size(), word_char());
            2: text.insert(text.size(), punct_pick());
            3, 4: text.insert(text.size(), blank_pick());
            5, 6: begin
               text.insert(text.size(), CH_QUOTE);
               repeat ($urandom_range(0, 6)) begin
                  c = 8'($urandom_range(0, 255));
                  text.insert(text.size(), c == CH_QUOTE ? "q" : c);
               end
               text.insert(text.size(), CH_QUOTE);
            end
            7: begin
               text.insert(text.size(), CH_SLASH);
               text.insert(text.size(), CH_SLASH);
               repeat ($urandom_range(0, 8)) begin
                  c = noise_char();
                  text.insert(text.size(), c == CH_NL ? "n" : c);
               end
               text.insert(text.size(), CH_NL);
            end
            8: begin
               text.insert(text.size(), CH_SLASH);
               text.insert(text.size(), CH_STAR);
               repeat ($urandom_range(0, 8)) text.insert(text.size(), noise_char());
               if ($urandom_range(0, 1) == 0) text.insert(text.size(), CH_STAR);
               text.insert(text.size(), CH_STAR);
               text.insert(text.size(), CH_SLASH);
            end
            9: begin
               text.insert(text.size(), CH_SLASH);
               text.insert(text.size(), noise_char());
            end
            default: repeat ($urandom_range(1, 3)) text.insert(text.size(), noise_char());
         endcase
      end
      while (text.size() > goal) text.delete(text.size() - 1);
   endfunction

   task automatic test_slash_handling();
      send_text("a/b");
      send_text("/");
      send_text("x/*");
      wait_drained();
   endtask

   task automatic test_strings();
      // closing quote followed straight by a new string, left open at the end
      send_text("\"a\"\"");
      wait_drained();
   endtask

   task automatic test_comments();
      send_text("//c");
      send_text("/***/q");
      wait_drained();
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(" ", 1'b1);
      wait_drained();
   endtask

   // long receiver hold while bytes keep coming, input must stall
   task automatic test_backpressure();
      sender_idles = 1'b0;
      stall_order = 60;
      send_text("a+(/b)*c/d=e;f,g.h^[i]{j}-/k");
      wait_drained();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_texts(input int budget);
      logic [7:0] text[$];
      int goal;
      int first;
      first = bytes_sent;
      while (bytes_sent - first < budget) begin
         sender_idles = ($urandom_range(0, 4) != 0);
         receiver_idles = ($urandom_range(0, 4) != 0);
         goal = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 30);
         build_text(text, goal);
         foreach (text[i]) send_byte(text[i], i == text.size() - 1);
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // result side ready, with random and ordered holds
   initial begin : receiver
      int hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_order > 0) begin
            hold = stall_order;
            stall_order = 0;
         end
         if (hold == 0 && receiver_idles && $urandom_range(0, 6) == 0) hold = idle_len();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected transaction: out_byte %0h byte_position %0d",
                   rsp_if.out_byte, rsp_if.byte_position);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_if.out_byte));
            check_field("byte_valid", 32'(want.byte_valid), 32'(rsp_if.byte_valid));
            check_field("token_start", 32'(want.token_start), 32'(rsp_if.token_start));
            check_field("is_string", 32'(want.is_string), 32'(rsp_if.is_string));
            check_field("byte_position", want.byte_position, rsp_if.byte_position);
            check_field("done_res", 32'(want.done_res), 32'(rsp_if.done_res));
            check_field("error_code", 32'(want.error_code), 32'(rsp_if.error_code));
         end
      end
   end

   // main sequence
   initial begin
      lexer_clear();
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.in_last <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_slash_handling();
      test_strings();
      test_comments();
      test_byte_extremes();
      test_backpressure();
      test_random_texts(1800);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/slbs_pkg.sv
src/slbs_if.sv
src/source_lexer_byte_stream.sv
bench/tb_top.sv
